// ----- design/cws_pkg.sv -----
// Package: shared constants and types for the coincidence window sorter.
`default_nettype none
package cws_pkg;
   localparam int TIME_BITS_DEF   = 48;
   localparam int ENERGY_BITS_DEF = 16;
   localparam int INDEX_BITS_DEF  = 32;
   localparam int WINDOW_BITS     = 20;
   localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 20'd400;
   localparam int QUEUE_DEPTH     = 4;
   localparam logic [1:0] TOP_KEPT = 2'd2;

   typedef enum logic {
      CMD_SINGLE = 1'b0,
      CMD_FLUSH  = 1'b1
   } cws_cmd_type;

   // per-beat control passed from front to back
   typedef struct packed {
      logic close_win;
      logic add_single;
   } cws_ctl_type;
endpackage
`default_nettype wire

// ----- design/cws_intf.sv -----
// Interfaces: request and response channels of the coincidence window sorter.
`default_nettype none
interface cws_req_if #(
   parameter int TIME_BITS   = 48,
   parameter int ENERGY_BITS = 16
);
   logic                   valid;
   logic                   ready;
   logic                   command;
   logic [TIME_BITS-1:0]   timestamp;
   logic [ENERGY_BITS-1:0] energy;

   modport source (output valid, command, timestamp, energy, input ready);
   modport sink   (input valid, command, timestamp, energy, output ready);
endinterface

interface cws_rsp_if #(
   parameter int INDEX_BITS = 32
);
   logic                  valid;
   logic                  ready;
   logic [INDEX_BITS-1:0] first_index;
   logic [INDEX_BITS-1:0] second_index;

   modport source (output valid, first_index, second_index, input ready);
   modport sink   (input valid, first_index, second_index, output ready);
endinterface
`default_nettype wire

// ----- design/cws_queue.sv -----
// Small flip-flop FIFO between the front and back parts.
`default_nettype none
module cws_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      head_data,
   output logic                  full,
   output logic                  empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule
`default_nettype wire

// ----- design/cws_front.sv -----
// Front part: accepts beats, numbers singles, decides window closes.
`default_nettype none
module cws_front #(
   parameter int TIME_BITS   = cws_pkg::TIME_BITS_DEF,
   parameter int ENERGY_BITS = cws_pkg::ENERGY_BITS_DEF,
   parameter int INDEX_BITS  = cws_pkg::INDEX_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   cws_req_if.sink                            req_if,
   input  wire logic                          csr_we,
   input  wire logic [cws_pkg::WINDOW_BITS-1:0] csr_wdata,
   input  wire logic                          q_full,
   output logic                               q_push,
   output cws_pkg::cws_ctl_type               q_ctl,
   output logic [INDEX_BITS-1:0]              q_index,
   output logic [ENERGY_BITS-1:0]             q_energy
);
   import cws_pkg::*;

   localparam int CMP_W = (TIME_BITS > WINDOW_BITS) ? TIME_BITS : WINDOW_BITS;

   logic [WINDOW_BITS-1:0] window_ff, window_in;
   logic [TIME_BITS-1:0]   start_ff, start_in;
   logic                   open_ff, open_in;
   logic [INDEX_BITS-1:0]  seq_ff, seq_in;
   logic [CMP_W-1:0]       ts_x, start_x, dist_x;
   logic                   accept, is_flush, expired;

   assign req_if.ready = !q_full;
   assign accept       = req_if.valid && !q_full;
   assign is_flush     = (req_if.command == CMD_FLUSH);

   assign ts_x    = CMP_W'(req_if.timestamp);
   assign start_x = CMP_W'(start_ff);
   assign dist_x  = ts_x - start_x;
   assign expired = !open_ff || ((ts_x >= start_x) && (dist_x >= CMP_W'(window_ff)));

   always_comb begin
      window_in = csr_we ? csr_wdata : window_ff;
      start_in  = start_ff;
      open_in   = open_ff;
      seq_in    = seq_ff;
      if (accept) begin
         if (is_flush) begin
            open_in = 1'b0;
         end else begin
            seq_in = seq_ff + 1'b1;
            if (expired) begin
               open_in  = 1'b1;
               start_in = req_if.timestamp;
            end
         end
      end
   end

   assign q_push           = accept;
   assign q_ctl.close_win  = is_flush || expired;
   assign q_ctl.add_single = !is_flush;
   assign q_index          = seq_ff;
   assign q_energy         = req_if.energy;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
         start_ff  <= '0;
         open_ff   <= 1'b0;
         seq_ff    <= '0;
      end else begin
         window_ff <= window_in;
         start_ff  <= start_in;
         open_ff   <= open_in;
         seq_ff    <= seq_in;
      end
   end
endmodule
`default_nettype wire

// ----- design/cws_back.sv -----
// Back part: keeps the running top two and emits a pair when a window with two or more singles closes.
`default_nettype none
module cws_back #(
   parameter int ENERGY_BITS = cws_pkg::ENERGY_BITS_DEF,
   parameter int INDEX_BITS  = cws_pkg::INDEX_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   q_empty,
   input  wire cws_pkg::cws_ctl_type   q_ctl,
   input  wire logic [INDEX_BITS-1:0]  q_index,
   input  wire logic [ENERGY_BITS-1:0] q_energy,
   output logic                        q_pop,
   cws_rsp_if.source                   rsp_if
);
   import cws_pkg::*;

   logic [1:0]             count_ff, count_in, count_eff;
   logic [INDEX_BITS-1:0]  best_idx_ff, best_idx_in, run_idx_ff, run_idx_in;
   logic [ENERGY_BITS-1:0] best_en_ff, best_en_in, run_en_ff, run_en_in;
   logic [ENERGY_BITS-1:0] best_en_eff, run_en_eff;
   logic [INDEX_BITS-1:0]  first_ff, first_in, second_ff, second_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   emit, out_free;

   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign emit     = q_ctl.close_win && (count_ff == TOP_KEPT);
   assign q_pop    = !q_empty && (!emit || out_free);

   always_comb begin
      count_eff   = q_ctl.close_win ? 2'd0 : count_ff;
      best_en_eff = q_ctl.close_win ? '0 : best_en_ff;
      run_en_eff  = q_ctl.close_win ? '0 : run_en_ff;
      count_in    = count_ff;
      best_idx_in = best_idx_ff;
      best_en_in  = best_en_ff;
      run_idx_in  = run_idx_ff;
      run_en_in   = run_en_ff;
      if (q_pop) begin
         count_in    = count_eff;
         best_en_in  = best_en_eff;
         run_en_in   = run_en_eff;
         if (q_ctl.close_win) begin
            best_idx_in = '0;
            run_idx_in  = '0;
         end
         if (q_ctl.add_single) begin
            if (count_eff == 2'd0) begin
               best_idx_in = q_index;
               best_en_in  = q_energy;
               count_in    = 2'd1;
            end else if (q_energy > best_en_eff) begin
               run_idx_in  = best_idx_ff;
               run_en_in   = best_en_eff;
               best_idx_in = q_index;
               best_en_in  = q_energy;
               count_in    = TOP_KEPT;
            end else if (count_eff < TOP_KEPT || q_energy > run_en_eff) begin
               run_idx_in = q_index;
               run_en_in  = q_energy;
               count_in   = TOP_KEPT;
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      first_in     = first_ff;
      second_in    = second_ff;
      if (q_pop && emit) begin
         rsp_valid_in = 1'b1;
         first_in     = best_idx_ff;
         second_in    = run_idx_ff;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.first_index  = first_ff;
   assign rsp_if.second_index = second_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= 2'd0;
         best_idx_ff  <= '0;
         best_en_ff   <= '0;
         run_idx_ff   <= '0;
         run_en_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         best_idx_ff  <= best_idx_in;
         best_en_ff   <= best_en_in;
         run_idx_ff   <= run_idx_in;
         run_en_ff    <= run_en_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      first_ff  <= first_in;
      second_ff <= second_in;
   end
endmodule
`default_nettype wire

// ----- design/coincidence_window_sorter.sv -----
// Top level: coincidence window sorter, front part, beat queue and back part.
// Throughput: one beat per cycle on req_if while the queue is not full.
// Path: the beat that closes a window is written into the queue; when the back pops it,
//   the pair is registered in the back's output register and raised on rsp_if.
// Reset: synchronous, active high; clears window, sequence and queue state,
//   sets the window width register to 400 ticks.
`default_nettype none
module coincidence_window_sorter #(
   parameter int TIME_BITS   = cws_pkg::TIME_BITS_DEF,
   parameter int ENERGY_BITS = cws_pkg::ENERGY_BITS_DEF,
   parameter int INDEX_BITS  = cws_pkg::INDEX_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   cws_req_if.sink                              req_if,
   cws_rsp_if.source                            rsp_if,
   input  wire logic                            csr_we,
   input  wire logic [cws_pkg::WINDOW_BITS-1:0] csr_wdata
);
   import cws_pkg::*;

   localparam int CTL_W   = $bits(cws_ctl_type);
   localparam int ENTRY_W = CTL_W + INDEX_BITS + ENERGY_BITS;

   cws_ctl_type            f_ctl, b_ctl;
   logic [INDEX_BITS-1:0]  f_index, b_index;
   logic [ENERGY_BITS-1:0] f_energy, b_energy;
   logic                   q_push, q_pop, q_full, q_empty;
   logic [ENTRY_W-1:0]     q_head;

   cws_front #(
      .TIME_BITS  (TIME_BITS),
      .ENERGY_BITS(ENERGY_BITS),
      .INDEX_BITS (INDEX_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_if   (req_if),
      .csr_we   (csr_we),
      .csr_wdata(csr_wdata),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_ctl    (f_ctl),
      .q_index  (f_index),
      .q_energy (f_energy)
   );

   cws_queue #(
      .WIDTH(ENTRY_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_data({f_ctl, f_index, f_energy}),
      .pop      (q_pop),
      .head_data(q_head),
      .full     (q_full),
      .empty    (q_empty)
   );

   assign b_ctl    = cws_ctl_type'(q_head[ENTRY_W-1 -: CTL_W]);
   assign b_index  = q_head[ENERGY_BITS +: INDEX_BITS];
   assign b_energy = q_head[ENERGY_BITS-1:0];

   cws_back #(
      .ENERGY_BITS(ENERGY_BITS),
      .INDEX_BITS (INDEX_BITS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_ctl   (b_ctl),
      .q_index (b_index),
      .q_energy(b_energy),
      .q_pop   (q_pop),
      .rsp_if  (rsp_if)
   );

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_full))
      else $error("beat pushed into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(q_pop && q_empty))
      else $error("pop from empty queue");

   a_rsp_from_pop: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_if.valid) |-> $past(q_pop))
      else $error("result raised without a queue pop");
endmodule
`default_nettype wire

// ----- tb/coincidence_window_sorter_checker.sv -----
// Checker: predicts coincidence pairs from accepted beats and compares the response beats.
module coincidence_window_sorter_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   cws_req_if                                   req_if,
   cws_rsp_if                                   rsp_if,
   input  wire logic                            csr_we,
   input  wire logic [cws_pkg::WINDOW_BITS-1:0] csr_wdata,
   output int                                   mismatch_count,
   output int                                   pairs_pending
);
   import cws_pkg::*;

   typedef struct packed {
      logic [INDEX_BITS_DEF-1:0] first_index;
      logic [INDEX_BITS_DEF-1:0] second_index;
   } coinc_pair_type;

   coinc_pair_type             expected_pairs[$];
   logic [WINDOW_BITS-1:0]     window_width;
   logic [TIME_BITS_DEF-1:0]   win_origin;
   logic                       window_open;
   logic [1:0]                 window_count;
   logic [INDEX_BITS_DEF-1:0]  best_index;
   logic [INDEX_BITS_DEF-1:0]  runner_index;
   logic [INDEX_BITS_DEF-1:0]  next_seq;
   logic [ENERGY_BITS_DEF-1:0] best_energy;
   logic [ENERGY_BITS_DEF-1:0] runner_energy;
   int                         errors = 0;

   task automatic close_window();
      coinc_pair_type closed;
      if (window_open && window_count >= TOP_KEPT) begin
         closed = '{first_index: best_index, second_index: runner_index};
         expected_pairs.insert(expected_pairs.size(), closed);
      end
      window_open   = 1'b0;
      window_count  = '0;
      best_index    = '0;
      best_energy   = '0;
      runner_index  = '0;
      runner_energy = '0;
   endtask

   task automatic predict_beat(input cws_cmd_type cmd, input logic [TIME_BITS_DEF-1:0] ts,
                               input logic [ENERGY_BITS_DEF-1:0] e);
      logic [INDEX_BITS_DEF-1:0] idx;
      if (cmd == CMD_FLUSH) begin
         close_window();
         return;
      end
      idx      = next_seq;
      next_seq = next_seq + 1'b1;
      // a stamp behind the window start always joins the open window
      if (!window_open || (ts >= win_origin && (ts - win_origin) >= window_width)) begin
         close_window();
         window_open = 1'b1;
         win_origin  = ts;
      end
      if (window_count == 0) begin
         best_index   = idx;
         best_energy  = e;
         window_count = 2'd1;
      end else if (e > best_energy) begin
         runner_index  = best_index;
         runner_energy = best_energy;
         best_index    = idx;
         best_energy   = e;
         window_count  = TOP_KEPT;
      end else if (window_count < TOP_KEPT || e > runner_energy) begin
         runner_index  = idx;
         runner_energy = e;
         window_count  = TOP_KEPT;
      end
   endtask

   always @(posedge clock) begin
      coinc_pair_type got, want;
      if (reset) begin
         window_width = WINDOW_RESET;
         win_origin   = '0;
         next_seq     = '0;
         window_open  = 1'b1;
         window_count = '0;
         close_window();
         expected_pairs.delete();
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got = '{first_index: rsp_if.first_index, second_index: rsp_if.second_index};
            if (expected_pairs.size() == 0) begin
               $error("unexpected pair beat: first_index %0d second_index %0d",
                      got.first_index, got.second_index);
               errors++;
            end else begin
               want = expected_pairs.pop_front();
               if (got.first_index !== want.first_index) begin
                  $error("first_index: expected %0d, actual %0d",
                         want.first_index, got.first_index);
                  errors++;
               end
               if (got.second_index !== want.second_index) begin
                  $error("second_index: expected %0d, actual %0d",
                         want.second_index, got.second_index);
                  errors++;
               end
            end
         end
         if (req_if.valid && req_if.ready) begin
            predict_beat(cws_cmd_type'(req_if.command), req_if.timestamp, req_if.energy);
         end
         if (csr_we) begin
            window_width = csr_wdata;
         end
      end
      mismatch_count <= errors;
      pairs_pending  <= expected_pairs.size();
   end
endmodule

// ----- tb/coincidence_window_sorter_tb.sv -----
// Testbench top: clock, reset, stimulus and verdict for the coincidence window sorter.
module coincidence_window_sorter_tb;
   import cws_pkg::*;

   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 6;
   localparam int PHASE_ITEMS  = 280;
   localparam logic [TIME_BITS_DEF-1:0] STAMP_MAX = '1;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_we = 1'b0;
   logic [WINDOW_BITS-1:0] csr_wdata = WINDOW_RESET;
   int                     mismatch_count;
   int                     pairs_pending;
   int                     idle_cycles = 0;
   int                     ready_hold = 0;
   int                     rsp_stall;
   bit                     steady_send = 1'b0;
   logic [WINDOW_BITS-1:0] phase_width[5] = '{20'd1, 20'd1048575, 20'd0, 20'd25, WINDOW_RESET};

   cws_req_if req_if ();
   cws_rsp_if rsp_if ();

   coincidence_window_sorter dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   coincidence_window_sorter_checker pair_checker (
      .clock          (clock),
      .reset          (reset),
      .req_if         (req_if),
      .rsp_if         (rsp_if),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pairs_pending  (pairs_pending)
   );

   always #5 clock = ~clock;

   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // response side: runs of ready, then stalls of random length
   always @(posedge clock) begin
      if (ready_hold != 0) begin
         ready_hold <= ready_hold - 1;
      end else begin
         rsp_stall = idle_length();
         if (rsp_stall == 0) begin
            rsp_if.ready <= 1'b1;
            ready_hold   <= $urandom_range(0, 20);
         end else begin
            rsp_if.ready <= 1'b0;
            ready_hold   <= rsp_stall - 1;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic send_beat(input cws_cmd_type cmd, input logic [TIME_BITS_DEF-1:0] ts,
                            input logic [ENERGY_BITS_DEF-1:0] e);
      int gap;
      req_if.valid     <= 1'b1;
      req_if.command   <= cmd;
      req_if.timestamp <= ts;
      req_if.energy    <= e;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      gap = steady_send ? 0 : idle_length();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_for_pairs();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pairs_pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [TIME_BITS_DEF-1:0]   stamp;
      logic [ENERGY_BITS_DEF-1:0] energy;
      int                         width;
      int                         r;
      req_if.valid     = 1'b0;
      req_if.command   = CMD_SINGLE;
      req_if.timestamp = '0;
      req_if.energy    = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset width of 400 ticks
      send_beat(CMD_FLUSH, '0, '0);             // nothing open
      send_beat(CMD_SINGLE, 48'd0, 16'd0);
      send_beat(CMD_FLUSH, STAMP_MAX, 16'hFFFF); // lone single, no pair
      send_beat(CMD_SINGLE, 48'd100, 16'hFFFF);
      send_beat(CMD_SINGLE, 48'd150, 16'hFFFF); // tie keeps the earlier one first
      send_beat(CMD_SINGLE, 48'd200, 16'hFFFF);
      send_beat(CMD_SINGLE, 48'd499, 16'd10);   // one tick inside
      send_beat(CMD_SINGLE, 48'd500, 16'd5);    // exactly one width: closes
      send_beat(CMD_SINGLE, 48'd510, 16'd7);
      send_beat(CMD_SINGLE, 48'd600, 16'd3);
      send_beat(CMD_SINGLE, 48'd50, 16'd9);     // behind the window start
      send_beat(CMD_FLUSH, '0, '0);
      send_beat(CMD_SINGLE, STAMP_MAX - 1, 16'd100);
      send_beat(CMD_SINGLE, STAMP_MAX, 16'd200);
      send_beat(CMD_FLUSH, '0, '0);
      send_beat(CMD_SINGLE, STAMP_MAX, 16'd0);
      send_beat(CMD_SINGLE, 48'd0, 16'd1);
      send_beat(CMD_SINGLE, 48'd399, 16'd1);
      send_beat(CMD_SINGLE, 48'd400, 16'hFFFF);
      send_beat(CMD_SINGLE, 48'd401, 16'hFFFE);
      send_beat(CMD_FLUSH, '0, '0);
      send_beat(CMD_FLUSH, '0, '0);

      foreach (phase_width[p]) begin
         wait_for_pairs();
         csr_we    <= 1'b1;
         csr_wdata <= phase_width[p];
         @(posedge clock);
         csr_we <= 1'b0;
         width = int'(phase_width[p]);
         stamp = TIME_BITS_DEF'({$urandom, $urandom});
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 40 == 0) steady_send = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 3) stamp = stamp - $urandom_range(0, 2 * width + 5);
            else if (r < 8) stamp = TIME_BITS_DEF'({$urandom, $urandom});
            else if (r < 13) stamp = stamp + width;
            else stamp = stamp + $urandom_range(0, width / 3 + 1);
            r = $urandom_range(0, 99);
            if (r < 25) energy = ENERGY_BITS_DEF'($urandom_range(0, 3));
            else if (r < 30) energy = '1;
            else energy = ENERGY_BITS_DEF'($urandom_range(0, 65535));
            if ($urandom_range(0, 99) < 5) begin
               send_beat(CMD_FLUSH, TIME_BITS_DEF'({$urandom, $urandom}),
                         ENERGY_BITS_DEF'($urandom));
            end else begin
               send_beat(CMD_SINGLE, stamp, energy);
            end
            if ($urandom_range(0, 199) == 0) wait_for_pairs();
         end
      end

      wait_for_pairs();
      if (mismatch_count == 0 && pairs_pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule

// ----- files.f -----
design/cws_pkg.sv
design/cws_intf.sv
design/cws_queue.sv
design/cws_front.sv
design/cws_back.sv
design/coincidence_window_sorter.sv
tb/coincidence_window_sorter_checker.sv
tb/coincidence_window_sorter_tb.sv
